/* sv/adcc_pkg.sv */
// shared types and constants for the adc channel conditioner
package adcc_pkg;

    typedef struct packed {
        logic [11:0] sample;
        logic [7:0]  raw_channel;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  logical_channel;
        logic [16:0] value_mv;
        logic [2:0]  key_code;
        logic        key_down;
        logic        key_held;
        logic        key_up;
        logic        key_idle;
    } out_item_t;

    localparam logic [2:0] NO_KEY   = 3'd5;
    localparam int         TRIM_LEN = 10;

    localparam logic [2:0] CFG_MV   = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_KEY4 = 3'd4;
    localparam logic [2:0] CFG_TOL  = 3'd5;

endpackage

/* sv/adcc_sorter.sv */
// trimmed mean over ten samples by sequential compare and swap
module adcc_sorter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [11:0] vals [10],
    output logic        done,
    output logic [11:0] mean
);
    import adcc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    // 2^16 / 6 rounded up, exact for sums below 2^15
    localparam logic [28:0] DIV6_RECIP = 29'd10923;

    logic [1:0]  state_reg;
    logic [3:0]  i_reg;
    logic [3:0]  j_reg;
    logic [11:0] arr_reg [10];
    logic [14:0] sum_reg;
    logic [11:0] q_reg;
    logic [28:0] div6_prod;

    assign div6_prod = 29'(sum_reg) * DIV6_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= (state_reg == S_DIV);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        arr_reg   <= vals;
                        i_reg     <= 4'd0;
                        j_reg     <= 4'd1;
                        state_reg <= S_SORT;
                    end
                end
                S_SORT:
                begin
                    if (arr_reg[i_reg] > arr_reg[j_reg])
                    begin
                        arr_reg[i_reg] <= arr_reg[j_reg];
                        arr_reg[j_reg] <= arr_reg[i_reg];
                    end
                    if (j_reg == 4'(TRIM_LEN - 1))
                    begin
                        if (i_reg == 4'(TRIM_LEN - 2))
                        begin
                            state_reg <= S_SUM;
                            i_reg     <= 4'd2;
                            sum_reg   <= '0;
                        end
                        else
                        begin
                            i_reg <= i_reg + 4'd1;
                            j_reg <= i_reg + 4'd2;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 4'd1;
                    end
                end
                S_SUM:
                begin
                    sum_reg <= sum_reg + 15'(arr_reg[i_reg]);
                    if (i_reg == 4'd7)
                        state_reg <= S_DIV;
                    i_reg <= i_reg + 4'd1;
                end
                S_DIV:
                begin
                    // division by six through a reciprocal multiply
                    q_reg     <= 12'(div6_prod >> 16);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign mean = q_reg;
endmodule

/* sv/adc_channel_conditioner.sv */
// top level of the adc channel conditioner
//
// usage: one sample and raw channel number enter per transfer on the in
// channel (in_valid/in_ready); samples on raw channels above the top channel
// are dropped without a result. every other sample yields one result on the
// out channel (out_valid/out_ready). averaging state for channels 1, 2, 4
// lies in one ring memory plus a sum memory, both synchronous reads, so an
// item takes a read step, an update step, the scaling steps (average,
// multiply, multiply, reciprocal divide) and an output step; no new item is
// taken until the result has been put out. a channel-3 sample that is not
// the tenth skips the scaling; a tenth channel-3 sample adds the sort
// engine: a compare/swap pass over every pair, a sum of the middle six and
// a divide, after which the mean is taken. after reset the ring memory is
// cleared by a pass over all its addresses during which no sample is taken;
// configuration writes take effect at once and belong between items.
// the result is held in an output register until taken; a stalled receiver
// stops the next item only when it reaches the output.
module adc_channel_conditioner #(
    parameter int SAMPLE_COUNT = 8,
    parameter int TOP_CHANNEL  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  adcc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output adcc_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data
);
    import adcc_pkg::*;

    localparam int SW    = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int DEPTH = 3 * SAMPLE_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = 12 + $clog2(SAMPLE_COUNT + 1);

    // average by reciprocal multiply, exact for every sum below 2^SUMW
    localparam int     AVG_K = SUMW + SW;
    localparam longint AVG_M = ((longint'(1) << AVG_K) + longint'(SAMPLE_COUNT - 1))
                               / longint'(SAMPLE_COUNT);
    localparam int     PW    = 2 * SUMW + 2;

    // reciprocals for the divisions by 100 and 1000 over the product ranges
    localparam logic [20:0] RECIP_100        = 21'd1342178;
    localparam int          RECIP_100_SHIFT  = 27;
    localparam logic [27:0] RECIP_1000       = 28'd137438954;
    localparam int          RECIP_1000_SHIFT = 37;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_SORT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [7:0]  mv_reg;
    logic [11:0] key1_reg, key2_reg, key3_reg, key4_reg;
    logic [7:0]  tol_reg;

    logic [2:0]  state_reg;
    logic [AW-1:0] clr_reg;
    logic [SW-1:0] slot_reg;
    logic [3:0]  fill_reg;
    logic [2:0]  hist0_reg, hist1_reg, hist2_reg;
    logic [11:0] avg3_reg;
    logic [11:0] trim_mem [TRIM_LEN];

    logic [11:0] ring_mem [DEPTH];
    logic [SUMW-1:0] sum_mem [3];
    logic [11:0] ring_q;
    logic [SUMW-1:0] sum_q;

    logic [11:0] s_reg;
    logic [2:0]  ch_reg;
    logic [1:0]  idx_reg;
    logic [AW-1:0] addr_reg;
    logic [SUMW-1:0] sumr_reg;
    logic [1:0]  step_reg;
    logic [11:0] avg_reg;
    logic [19:0] prod_reg;
    logic [26:0] prod2_reg;
    logic [16:0] quot_reg;
    logic        mul2_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic        sort_start, sort_done;
    logic [11:0] sort_mean;

    logic [SW-1:0] slot_next;
    logic [2:0]  ch_next;
    logic [1:0]  idx_next;
    logic [2:0]  code_new;
    logic [SUMW-1:0] sum_new;
    logic [PW-1:0] avg_prod;
    logic [40:0] div100_prod;
    logic [54:0] div1000_prod;
    out_item_t   out_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg   <= 8'd81;
            key1_reg <= 12'd4021;
            key2_reg <= 12'd3915;
            key3_reg <= 12'd3638;
            key4_reg <= 12'd2873;
            tol_reg  <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MV:   mv_reg   <= cfg_data[7:0];
                CFG_KEY1: key1_reg <= cfg_data;
                CFG_KEY2: key2_reg <= cfg_data;
                CFG_KEY3: key3_reg <= cfg_data;
                CFG_KEY4: key4_reg <= cfg_data;
                CFG_TOL:  tol_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (in_data.raw_channel == 8'(TOP_CHANNEL))
            slot_next = (slot_reg == SW'(SAMPLE_COUNT - 1)) ? '0 : slot_reg + SW'(1);
        ch_next = in_data.raw_channel[0] ? 3'((in_data.raw_channel + 8'd1) >> 1) : 3'd0;
        case (ch_next)
            3'd1:    idx_next = 2'd0;
            3'd2:    idx_next = 2'd1;
            default: idx_next = 2'd2;
        endcase
    end

    function automatic logic in_win(input logic [11:0] s, input logic [11:0] lvl,
                                    input logic [7:0] tol);
        logic signed [14:0] v, lo, hi;
        v  = signed'({3'b0, s});
        lo = signed'({3'b0, lvl}) - signed'({7'b0, tol});
        hi = signed'({3'b0, lvl}) + signed'({7'b0, tol});
        return (v > lo) && (v < hi);
    endfunction

    always_comb
    begin
        if (in_win(s_reg, key1_reg, tol_reg))      code_new = 3'd4;
        else if (in_win(s_reg, key2_reg, tol_reg)) code_new = 3'd3;
        else if (in_win(s_reg, key3_reg, tol_reg)) code_new = 3'd2;
        else if (in_win(s_reg, key4_reg, tol_reg)) code_new = 3'd1;
        else if ({1'b0, s_reg} < 13'(tol_reg) + 13'd10) code_new = 3'd0;
        else code_new = NO_KEY;
        sum_new = ((sum_q >= SUMW'(ring_q)) ? sum_q - SUMW'(ring_q) : sum_q)
                  + SUMW'(s_reg);
    end

    assign avg_prod     = PW'(sumr_reg) * PW'(AVG_M);
    assign div100_prod  = 41'(prod_reg) * 41'(RECIP_100);
    assign div1000_prod = 55'(prod2_reg) * 55'(RECIP_1000);

    // synchronous memory ports
    always_ff @(posedge clk)
    begin
        ring_q <= ring_mem[addr_reg];
        sum_q  <= sum_mem[idx_reg];
        if (state_reg == S_CLEAR)
        begin
            ring_mem[clr_reg] <= '0;
            if (clr_reg < AW'(3))
                sum_mem[clr_reg[1:0]] <= '0;
        end
        else if (state_reg == S_UPD && ch_reg != 3'd0 && ch_reg != 3'd3)
        begin
            ring_mem[addr_reg] <= s_reg;
            sum_mem[idx_reg]   <= sum_new;
        end
        if (state_reg == S_IDLE && in_valid && ch_next == 3'd3
            && in_data.raw_channel <= 8'(TOP_CHANNEL))
            trim_mem[(fill_reg >= 4'(TRIM_LEN)) ? 4'd0 : fill_reg] <= in_data.sample;
    end

    assign sort_start = (state_reg == S_UPD) && (ch_reg == 3'd3) && (fill_reg == 4'd0);

    adcc_sorter u_sort (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .vals  (trim_mem),
        .done  (sort_done),
        .mean  (sort_mean)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            s_reg    <= in_data.sample;
            ch_reg   <= ch_next;
            idx_reg  <= idx_next;
            addr_reg <= AW'(idx_next) * AW'(SAMPLE_COUNT) + AW'(slot_next);
        end
        if (state_reg == S_UPD)
        begin
            mul2_reg <= (ch_reg == 3'd2) || (ch_reg == 3'd4);
            sumr_reg <= sum_new;
        end
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                2'd0: avg_reg <= 12'(avg_prod >> AVG_K);
                2'd1: prod_reg <= 20'((ch_reg == 3'd0) ? s_reg : avg_reg) * 20'(mv_reg);
                2'd2: prod2_reg <= 27'(prod_reg) * 27'd87;
                default:
                    quot_reg <= mul2_reg ? 17'(div1000_prod >> RECIP_1000_SHIFT)
                                         : 17'(div100_prod >> RECIP_100_SHIFT);
            endcase
        end
    end

    always_comb
    begin
        out_next                 = '0;
        out_next.logical_channel = ch_reg;
        out_next.key_code        = NO_KEY;
        if (ch_reg == 3'd0)
        begin
            out_next.value_mv = quot_reg;
            out_next.key_code = (hist1_reg == hist2_reg) ? hist1_reg : NO_KEY;
            if (hist0_reg == NO_KEY && hist1_reg == hist2_reg && hist2_reg <= 3'd4)
                out_next.key_down = 1'b1;
            else if (hist0_reg == hist1_reg && hist1_reg == hist2_reg
                     && hist2_reg <= 3'd4)
                out_next.key_held = 1'b1;
            else if (hist0_reg <= 3'd4 && hist0_reg == hist1_reg
                     && hist2_reg == NO_KEY)
                out_next.key_up = 1'b1;
            else
                out_next.key_idle = 1'b1;
        end
        else if (ch_reg == 3'd3)
            out_next.value_mv = 17'(avg3_reg);
        else if (ch_reg == 3'd2)
            out_next.value_mv = quot_reg + 17'd900;
        else
            out_next.value_mv = quot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            step_reg      <= '0;
            hist0_reg     <= NO_KEY;
            hist1_reg     <= NO_KEY;
            hist2_reg     <= NO_KEY;
            avg3_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && in_data.raw_channel <= 8'(TOP_CHANNEL))
                    begin
                        slot_reg  <= slot_next;
                        state_reg <= S_READ;
                        if (ch_next == 3'd3)
                            fill_reg <= (fill_reg >= 4'(TRIM_LEN - 1)) ? 4'd0
                                        : fill_reg + 4'd1;
                    end
                end
                S_READ: state_reg <= S_UPD;
                S_UPD:
                begin
                    if (ch_reg == 3'd0)
                    begin
                        hist0_reg <= hist1_reg;
                        hist1_reg <= hist2_reg;
                        hist2_reg <= code_new;
                    end
                    if (sort_start)
                        state_reg <= S_SORT;
                    else if (ch_reg == 3'd3)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_MUL;
                end
                S_SORT:
                begin
                    if (sort_done)
                    begin
                        avg3_reg  <= sort_mean;
                        state_reg <= S_OUT;
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= out_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
